@@ rtl/triangle_setup_gradients_unit_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef TRIANGLE_SETUP_GRADIENTS_UNIT_ASSERT_SVH
`define TRIANGLE_SETUP_GRADIENTS_UNIT_ASSERT_SVH

// clocked check, off while reset is high
`define TSG_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// clocked check that also holds across reset
`define TSG_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ rtl/tsg_pkg.sv @@
`default_nettype none
package tsg_pkg;

  localparam int COORD_FRAC_DEF = 4;
  localparam int COLOR_FRAC_DEF = 12;

  // widths cover the full parameter ranges
  localparam int PW   = 21;  // offset position
  localparam int DW   = 22;  // position delta
  localparam int VW   = 33;  // parameter value at a vertex
  localparam int VDW  = 34;  // parameter delta
  localparam int MW   = 56;  // multiplier product
  localparam int NUMW = 57;  // gradient numerator
  localparam int AW   = 45;  // doubled area
  localparam int NSHW = 5;   // numerator shift, up to 16
  localparam int DSHW = 3;   // denominator shift, up to 4

  localparam int IN_DATA_W  = 224;
  localparam int OUT_DATA_W = 288;
  localparam int OUT_USER_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        z;
    logic [31:0]        w;
    logic [15:0]        r;
    logic [15:0]        g;
    logic [15:0]        b;
    logic [15:0]        a;
    logic signed [31:0] s;
    logic signed [31:0] t;
  } vtx_t;

  typedef enum logic [3:0] {
    PID_R  = 4'd0,
    PID_G  = 4'd1,
    PID_B  = 4'd2,
    PID_A  = 4'd3,
    PID_Z  = 4'd4,
    PID_W  = 4'd5,
    PID_S  = 4'd6,
    PID_T  = 4'd7,
    PID_TW = 4'd8
  } pid_t;

  typedef enum logic [2:0] {
    CFG_MODE    = 3'd0,
    CFG_CULL    = 3'd1,
    CFG_VIEW_X  = 3'd2,
    CFG_VIEW_Y  = 3'd3,
    CFG_TEXTURE = 3'd4,
    CFG_ENABLE  = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] MODE_STRIP = 2'd1;
  localparam logic [1:0] MODE_FAN   = 2'd2;
  localparam logic [1:0] CULL_NEG   = 2'd1;
  localparam logic [1:0] CULL_POS   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_AREA0, S_AREA1, S_CULL,
    S_NX0, S_NX1, S_NX2, S_DIVX,
    S_NY0, S_NY1, S_NY2, S_DIVY,
    S_OUT
  } st_t;

  // output fraction bits minus input fraction bits
  function automatic int param_exp(logic [3:0] p, int color_frac);
    int e;
    e = 0;
    unique case (p)
      PID_R, PID_G, PID_B, PID_A: e = color_frac - 8;
      PID_Z:                      e = -4;
      PID_W:                      e = 2;
      default:                    e = 0;
    endcase
    return e;
  endfunction

  function automatic logic signed [VW-1:0] vert_val(vtx_t v, logic [3:0] p);
    logic signed [VW-1:0] r;
    r = '0;
    unique case (p)
      PID_R:         r = {17'b0, v.r};
      PID_G:         r = {17'b0, v.g};
      PID_B:         r = {17'b0, v.b};
      PID_A:         r = {17'b0, v.a};
      PID_Z:         r = {1'b0, v.z};
      PID_W, PID_TW: r = {1'b0, v.w};
      PID_S:         r = {v.s[31], v.s};
      PID_T:         r = {v.t[31], v.t};
      default:       r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/triangle_setup_gradients_unit.sv @@
`default_nettype none
// channel | dir | handshake            | contents
// s_axis  | in  | tvalid/tready        | one vertex word, tuser = restart
// m_axis  | out | tvalid/tready/tlast  | one parameter setup word, tuser = param id
// cfg     | in  | cfg_we               | register write, index cfg_addr
//
// A vertex that completes no triangle is taken in the idle state. A triangle
// passes two area states and the cull decision, then per parameter three
// numerator states and a divider pass of 73 quotient bits plus done, once for
// step_x and once for step_y, then an output state; the divider passes set the
// rate. A zero-area triangle goes straight to the output state per parameter.
// Synchronous active-high reset clears control and config, not the vertex
// store. s_axis_tready is high only while idle; a stalled output word holds.
module triangle_setup_gradients_unit #(
  parameter int COORD_FRAC_BITS = tsg_pkg::COORD_FRAC_DEF,
  parameter int COLOR_FRAC_BITS = tsg_pkg::COLOR_FRAC_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // pos_x, pos_y, depth, inv_w, red, green, blue, alpha, tex_s, tex_t
  input  wire logic [tsg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // restart
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // start_value, step_x, step_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
  // vert_c_x, vert_c_y
  output logic [tsg_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // param_id
  output logic [tsg_pkg::OUT_USER_W-1:0]         m_axis_tuser,
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [tsg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tsg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tsg_pkg::*;

  // config registers
  logic [1:0]         primitive_mode;
  logic [1:0]         cull_select;
  logic signed [11:0] view_x;
  logic signed [11:0] view_y;
  logic               texture_on;
  logic               block_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      primitive_mode <= '0;
      cull_select    <= '0;
      view_x         <= '0;
      view_y         <= '0;
      texture_on     <= 1'b0;
      block_on       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE:    primitive_mode <= cfg_data[1:0];
        CFG_CULL:    cull_select    <= cfg_data[1:0];
        CFG_VIEW_X:  view_x         <= cfg_data;
        CFG_VIEW_Y:  view_y         <= cfg_data;
        CFG_TEXTURE: texture_on     <= cfg_data[0];
        CFG_ENABLE:  block_on       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // incoming vertex
  vtx_t cur;
  always_comb begin
    cur.x = s_axis_tdata[15:0];
    cur.y = s_axis_tdata[31:16];
    cur.z = s_axis_tdata[63:32];
    cur.w = s_axis_tdata[95:64];
    cur.r = s_axis_tdata[111:96];
    cur.g = s_axis_tdata[127:112];
    cur.b = s_axis_tdata[143:128];
    cur.a = s_axis_tdata[159:144];
    cur.s = s_axis_tdata[191:160];
    cur.t = s_axis_tdata[223:192];
  end

  st_t state, state_next;

  vtx_t s0, s1;         // held vertices of the current primitive
  vtx_t va, vb, vc;     // triangle under setup
  logic [1:0] seen;
  logic       parity;
  logic [3:0] pid;

  logic signed [MW-1:0] mreg;
  logic signed [MW-1:0] acc;
  logic signed [AW-1:0] area;
  logic signed [63:0]   sx, sy;

  logic in_acc;
  logic [1:0] seen_eff;
  logic par_eff;
  logic tri_go;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign seen_eff = s_axis_tuser ? 2'd0 : seen;
  assign par_eff  = s_axis_tuser ? 1'b0 : parity;
  assign tri_go   = in_acc && block_on && (seen_eff == 2'd2);

  // offset positions
  function automatic logic signed [PW-1:0] off_pos(logic signed [15:0] p,
                                                    logic signed [11:0] o);
    return PW'(p) + (PW'(o) <<< COORD_FRAC_BITS);
  endfunction

  function automatic logic [15:0] sat16(logic signed [PW-1:0] v);
    logic [15:0] r;
    if (v > PW'(32767))       r = 16'h7fff;
    else if (v < -PW'(32768)) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

  logic signed [PW-1:0] pxa, pya, pxb, pyb, pxc, pyc;
  logic signed [DW-1:0] dxb, dyb, dxc, dyc;
  assign pxa = off_pos(va.x, view_x);
  assign pya = off_pos(va.y, view_y);
  assign pxb = off_pos(vb.x, view_x);
  assign pyb = off_pos(vb.y, view_y);
  assign pxc = off_pos(vc.x, view_x);
  assign pyc = off_pos(vc.y, view_y);
  assign dxb = DW'(pxb) - DW'(pxa);
  assign dyb = DW'(pyb) - DW'(pya);
  assign dxc = DW'(pxc) - DW'(pxa);
  assign dyc = DW'(pyc) - DW'(pya);

  // parameter values at the three vertices
  logic signed [VW-1:0]  a0;
  logic signed [VDW-1:0] db, dc;
  assign a0 = vert_val(va, pid);
  assign db = VDW'(vert_val(vb, pid)) - VDW'(a0);
  assign dc = VDW'(vert_val(vc, pid)) - VDW'(a0);

  // shared multiplier, operands picked by the sequencer
  logic signed [VDW-1:0] ma;
  logic signed [DW-1:0]  mb;
  logic signed [MW-1:0]  prod;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_AREA0: begin ma = VDW'(dxb); mb = dyc; end
      S_AREA1: begin ma = VDW'(dxc); mb = dyb; end
      S_NX0:   begin ma = db;        mb = dyc; end
      S_NX1:   begin ma = dc;        mb = dyb; end
      S_NY0:   begin ma = dc;        mb = dxb; end
      S_NY1:   begin ma = db;        mb = dxc; end
      default: ;
    endcase
    prod = MW'(ma) * MW'(mb);
  end

  // second product is subtracted from the first
  logic signed [NUMW-1:0] diff;
  assign diff = NUMW'(acc) - NUMW'(mreg);

  // scaling for the current parameter
  logic [NSHW-1:0]    nsh;
  logic [DSHW-1:0]    dsh;
  logic signed [63:0] start_val;
  always_comb begin
    int eg;
    int es;
    es = param_exp(pid, COLOR_FRAC_BITS);
    eg = COORD_FRAC_BITS + es;
    nsh = (eg > 0) ? NSHW'(eg) : '0;
    dsh = (eg < 0) ? DSHW'(-eg) : '0;
    // z is the only right shift and is never negative
    start_val = (es >= 0) ? (64'(a0) <<< es) : (64'(a0) >>> (-es));
  end

  logic div_start, div_done;
  logic signed [63:0] div_q;
  assign div_start = (state == S_NX2) || (state == S_NY2);

  tsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (diff),
    .den   (area),
    .nsh   (nsh),
    .dsh   (dsh),
    .done  (div_done),
    .quo   (div_q)
  );

  logic last_p;
  logic culled;
  assign last_p = texture_on ? (pid == PID_TW) : (pid == PID_W);
  assign culled = ((cull_select == CULL_NEG) && diff[NUMW-1]) ||
                  ((cull_select == CULL_POS) && !diff[NUMW-1] && (diff != '0));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (tri_go) state_next = S_AREA0;
      end
      S_AREA0: state_next = S_AREA1;
      S_AREA1: state_next = S_CULL;
      S_CULL:  state_next = culled ? S_IDLE : S_NX0;
      S_NX0:   state_next = (area == '0) ? S_OUT : S_NX1;
      S_NX1:   state_next = S_NX2;
      S_NX2:   state_next = S_DIVX;
      S_DIVX:  if (div_done) state_next = S_NY0;
      S_NY0:   state_next = S_NY1;
      S_NY1:   state_next = S_NY2;
      S_NY2:   state_next = S_DIVY;
      S_DIVY:  if (div_done) state_next = S_OUT;
      S_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_next = last_p ? S_IDLE : S_NX0;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // assembly control
  always_ff @(posedge clk) begin
    if (rst) begin
      seen   <= '0;
      parity <= 1'b0;
    end else if (in_acc && block_on) begin
      parity <= par_eff;
      if (seen_eff != 2'd2) begin
        seen <= seen_eff + 2'd1;
      end else if (primitive_mode == MODE_STRIP) begin
        seen   <= seen_eff;
        parity <= ~par_eff;
      end else if (primitive_mode == MODE_FAN) begin
        seen <= seen_eff;
      end else begin
        seen <= '0;
      end
    end
  end

  // vertex store and arithmetic registers (no reset)
  always_ff @(posedge clk) begin
    mreg <= prod;
    if (in_acc && block_on) begin
      if (seen_eff == 2'd0) begin
        s0 <= cur;
      end else if (seen_eff == 2'd1) begin
        s1 <= cur;
      end else begin
        vc  <= cur;
        pid <= PID_R;
        if (primitive_mode == MODE_STRIP) begin
          va <= par_eff ? s1 : s0;
          vb <= par_eff ? s0 : s1;
          s0 <= s1;
          s1 <= cur;
        end else begin
          va <= s0;
          vb <= s1;
          if (primitive_mode == MODE_FAN) s1 <= cur;
        end
      end
    end
    unique case (state)
      S_AREA1, S_NX1, S_NY1: acc <= mreg;
      S_CULL: area <= AW'(diff);
      S_NX0: begin
        if (area == '0) begin
          sx <= '0;
          sy <= '0;
        end
      end
      S_DIVX: if (div_done) sx <= div_q;
      S_DIVY: if (div_done) sy <= div_q;
      S_OUT:  if (m_axis_tready && !last_p) pid <= pid + 4'd1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {sat16(pyc), sat16(pxc), sat16(pyb), sat16(pxb),
                         sat16(pya), sat16(pxa), sy, sx, start_val};
  assign m_axis_tuser = pid;
  assign m_axis_tlast = last_p;

endmodule
`default_nettype wire

@@ rtl/tsg_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// q = trunc(num * 2^nsh / (den * 2^dsh)), saturated to signed 64 bits.
module tsg_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [tsg_pkg::NUMW-1:0] num,
  input  wire logic signed [tsg_pkg::AW-1:0]   den,
  input  wire logic [tsg_pkg::NSHW-1:0]        nsh,
  input  wire logic [tsg_pkg::DSHW-1:0]        dsh,
  output logic                                done,
  output logic signed [63:0]                  quo
);
  import tsg_pkg::*;

  localparam int NQW  = NUMW + 16;
  localparam int REMW = AW + 6;
  localparam int CW   = $clog2(NQW + 1);

  logic [NQW-1:0]  nq;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] dvs;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            neg;

  logic [NUMW-1:0] num_mag;
  logic [AW-1:0]   den_mag;
  logic [REMW-1:0] rem_sh;
  logic            ge;
  logic [NQW-1:0]  lim;
  logic [63:0]     mag;

  always_comb begin
    num_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    den_mag = den[AW-1] ? AW'(-den) : AW'(den);
    rem_sh  = {rem[REMW-2:0], nq[NQW-1]};
    ge      = rem_sh >= dvs;
    lim     = neg ? (NQW'(1) << 63) : ((NQW'(1) << 63) - NQW'(1));
    mag     = (nq > lim) ? lim[63:0] : nq[63:0];
    quo     = neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NQW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NUMW-1] ^ den[AW-1];
      nq  <= NQW'(num_mag) << nsh;
      dvs <= REMW'(den_mag) << dsh;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sh - dvs : rem_sh;
      nq  <= {nq[NQW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsg_checker.sv @@
`default_nettype none
module tsg_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [tsg_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input wire logic                          m_axis_tlast
);
  import tsg_pkg::*;
`include "triangle_setup_gradients_unit_assert.svh"

  // a pending output word is not dropped
  `TSG_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")

  // one vertex at a time: no input taken while a word is offered
  `TSG_ASSERT(a_excl, clk, rst, !(s_axis_tready && m_axis_tvalid), "input ready while output valid")

  // last word of a triangle is plain w or texture w
  `TSG_ASSERT(a_last_id, clk, rst, m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser == PID_W) || (m_axis_tuser == PID_TW), "last flag on wrong parameter")

  // nothing is offered right after reset
  `TSG_ASSERT_ALWAYS(a_rst_quiet, clk, $past(rst) |-> !m_axis_tvalid, "output valid after reset")

endmodule

bind triangle_setup_gradients_unit tsg_checker u_tsg_checker (.*);
`default_nettype wire

@@ test/tb_triangle_setup_gradients_unit.sv @@
`default_nettype none
module tb_triangle_setup_gradients_unit;
  import tsg_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RAND_ITEMS = 45;   // per config phase
  localparam int N_PHASES = 8;
  localparam int N_ROWS = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  triangle_setup_gradients_unit dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // one vertex as the block sees it
  typedef struct {
    logic signed [15:0] x, y;
    logic [31:0] z, w;
    logic [15:0] r, g, b, a;
    logic signed [31:0] s, t;
  } vert_t;

  // one parameter setup word
  typedef struct {
    logic [3:0] pid;
    longint start, sx, sy;
    logic [15:0] pos [6];
    logic last;
  } setup_word_t;

  // directed row; tri_known marks a zero-area triangle whose red start is typed in
  typedef struct {
    logic restart;
    logic signed [15:0] x, y;
    logic [31:0] z, w;
    logic [15:0] r, g, b, a;
    logic [31:0] s, t;
    logic tri_known;
    longint red_start;
  } row_t;

  row_t dir_tab [N_ROWS] = '{
    // zero-area triangle, all-ones then all-zeros attributes
    '{1, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      32'h7FFFFFFF, 32'h80000000, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 32'h12345678, 32'h40000000, 16'h8000, 16'h0001, 16'h7FFF, 16'h00FF,
      32'h80000000, 32'h7FFFFFFF, 1, 64'hFFFF0},
    // position extremes
    '{0, -16'sd32768, -16'sd32768, 32'hFFFFFFFF, 0, 16'hFFFF, 0, 16'hFFFF, 0,
      32'h80000000, 32'h7FFFFFFF, 0, 0},
    '{0, 16'sd32767, -16'sd32768, 0, 32'hFFFFFFFF, 0, 16'hFFFF, 0, 16'hFFFF,
      32'h7FFFFFFF, 32'h80000000, 0, 0},
    '{0, -16'sd32768, 16'sd32767, 32'h80000000, 32'h00000001, 16'h1234, 16'h5678,
      16'h9ABC, 16'hDEF0, 32'hFFFFFFFF, 32'h00000001, 0, 0},
    '{0, 16'sd32767, 16'sd32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, -16'sd32768, 16'sd32767, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0},
    '{0, 16'sd32767, -16'sd32768, 32'h00010000, 32'h40000000, 16'h0100, 16'h0200,
      16'h0300, 16'h0400, 32'h80000000, 32'h80000000, 0, 0},
    // ordinary triangle, ccw
    '{0, 0, 0, 32'h00010000, 32'h40000000, 16'h0000, 16'h1000, 16'h2000, 16'hFF00,
      32'h00040000, 32'hFFFC0000, 0, 0},
    '{0, 160, 0, 32'h00020000, 32'h20000000, 16'hFF00, 16'h1000, 16'h0000, 16'hFF00,
      32'h00080000, 32'h00000000, 0, 0},
    '{0, 0, 160, 32'h00030000, 32'h10000000, 16'h0000, 16'hFF00, 16'h8000, 16'h0000,
      32'hFFF00000, 32'h00100000, 0, 0},
    // restart drops a partial triangle
    '{1, 10, 20, 1, 2, 3, 4, 5, 6, 7, 8, 0, 0},
    '{0, 30, 40, 9, 10, 11, 12, 13, 14, 15, 16, 0, 0},
    '{1, -50, -60, 32'h00100000, 32'h3FFFFFFF, 16'h4000, 16'hC000, 16'h2000,
      16'hE000, 32'h01000000, 32'hFF000000, 0, 0},
    '{0, 500, -60, 32'h00200000, 32'h1FFFFFFF, 16'h8000, 16'h4000, 16'h1000,
      16'h0800, 32'h02000000, 32'hFE000000, 0, 0},
    '{0, -50, 700, 32'h00000000, 32'h0FFFFFFF, 16'h0000, 16'h0000, 16'hFFFF,
      16'h0001, 32'h00000000, 32'h00000000, 0, 0},
    // cw winding
    '{0, 0, 0, 32'h00050000, 32'h40000000, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
      32'h00001000, 32'h00002000, 0, 0},
    '{0, 0, 33, 32'h00060000, 32'h40000001, 16'h0200, 16'h0300, 16'h0400, 16'h0500,
      32'h00003000, 32'h00004000, 0, 0},
    '{0, 17, 0, 32'h00070000, 32'h40000002, 16'h0300, 16'h0500, 16'h0700, 16'h0900,
      32'h00005000, 32'h00006000, 0, 0}
  };

  // config phases: mode, cull, view_x, view_y, texture, enable
  logic [11:0] phase_tab [N_PHASES][6] = '{
    '{12'd1, 12'd1, 12'h7FF, 12'h800, 12'd1, 12'd1},
    '{12'd2, 12'd2, 12'h800, 12'h7FF, 12'd0, 12'd1},
    '{12'd3, 12'd3, 12'd5,   12'hFF9, 12'd1, 12'd1},   // unused codes
    '{12'd0, 12'd1, 12'd0,   12'd0,   12'd0, 12'd1},
    '{12'd1, 12'd2, 12'd100, 12'hF00, 12'd0, 12'd1},
    '{12'd2, 12'd0, 12'hFFF, 12'd1,   12'd1, 12'd1},
    '{12'd0, 12'd0, 12'd0,   12'd0,   12'd1, 12'd0},   // block off
    '{12'd0, 12'd0, 12'd0,   12'd0,   12'd0, 12'd1}
  };
  cfg_idx_t reg_order [6] = '{CFG_MODE, CFG_CULL, CFG_VIEW_X, CFG_VIEW_Y,
                              CFG_TEXTURE, CFG_ENABLE};

  // mirror of config and assembly state
  logic [1:0] mode_r, cull_r;
  logic signed [11:0] vx_r, vy_r;
  logic tex_r, en_r;
  vert_t held0, held1;
  int unsigned seen;
  logic parity;

  setup_word_t setup_q [$];
  int errs = 0;
  bit calm = 0;          // no idling on either side
  longint cycles = 0;
  vert_t prev_v;

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
    errs++;
  endtask

  // trunc(num * 2^e / den) toward zero, saturated to 64 bits
  function automatic longint scaled_quot(longint num, longint den, int e);
    bit neg;
    longint unsigned n, d, lim, q, r, mag;
    int up;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? 64'd0 - num : num;
    d = den < 0 ? 64'd0 - den : den;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    up = e > 0 ? e : 0;
    if (e < 0) d = d << (-e);
    q = n / d;
    r = n % d;
    if (q > (lim >> up)) begin
      mag = lim;
    end else begin
      mag = q << up;
      q = (r << up) / d;
      mag = (q > lim - mag) ? lim : mag + q;
    end
    if (neg) return mag == 64'h8000_0000_0000_0000 ? 64'sh8000_0000_0000_0000
                                                   : -longint'(mag);
    return longint'(mag);
  endfunction

  function automatic int frac_shift(pid_t p);
    case (p)
      PID_R, PID_G, PID_B, PID_A: return 4;   // color 12 frac bits vs 8
      PID_Z:                      return -4;
      PID_W:                      return 2;
      default:                    return 0;
    endcase
  endfunction

  function automatic longint attr_of(vert_t v, pid_t p);
    case (p)
      PID_R:         return longint'(v.r);
      PID_G:         return longint'(v.g);
      PID_B:         return longint'(v.b);
      PID_A:         return longint'(v.a);
      PID_Z:         return longint'(v.z);
      PID_W, PID_TW: return longint'(v.w);
      PID_S:         return longint'(v.s);
      default:       return longint'(v.t);
    endcase
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // push the setup words of one triangle; returns how many
  function automatic int plane_setup(vert_t va, vert_t vb, vert_t vc);
    vert_t v [3];
    longint px [3], py [3];
    longint area, a0, db, dc, nx, ny;
    setup_word_t sw;
    int cnt;
    pid_t p;
    v[0] = va; v[1] = vb; v[2] = vc;
    for (int i = 0; i < 3; i++) begin
      px[i] = longint'(v[i].x) + longint'(vx_r) * 16;
      py[i] = longint'(v[i].y) + longint'(vy_r) * 16;
    end
    area = (px[1] - px[0]) * (py[2] - py[0]) - (px[2] - px[0]) * (py[1] - py[0]);
    if (cull_r == CULL_NEG && area < 0) return 0;
    if (cull_r == CULL_POS && area > 0) return 0;
    cnt = tex_r ? 9 : 6;
    for (int n = 0; n < cnt; n++) begin
      p = pid_t'(n);
      a0 = attr_of(va, p);
      db = attr_of(vb, p) - a0;
      dc = attr_of(vc, p) - a0;
      sw.pid = p;
      sw.start = scaled_quot(a0, 1, frac_shift(p));
      sw.sx = 0;
      sw.sy = 0;
      if (area != 0) begin
        nx = db * (py[2] - py[0]) - dc * (py[1] - py[0]);
        ny = dc * (px[1] - px[0]) - db * (px[2] - px[0]);
        sw.sx = scaled_quot(nx, area, 4 + frac_shift(p));
        sw.sy = scaled_quot(ny, area, 4 + frac_shift(p));
      end
      for (int i = 0; i < 3; i++) begin
        sw.pos[2*i] = clamp16(px[i]);
        sw.pos[2*i+1] = clamp16(py[i]);
      end
      sw.last = (n == cnt - 1);
      setup_q.push_back(sw);
    end
    return cnt;
  endfunction

  // vertex assembly of one accepted word
  function automatic void assemble(vert_t cur, logic restart);
    vert_t a, b;
    int dummy;
    if (!en_r) return;
    if (restart) begin
      seen = 0;
      parity = 0;
    end
    if (seen < 2) begin
      if (seen == 0) held0 = cur; else held1 = cur;
      seen++;
      return;
    end
    if (mode_r == MODE_STRIP) begin
      a = parity ? held1 : held0;
      b = parity ? held0 : held1;
      held0 = held1;
      held1 = cur;
      parity = ~parity;
    end else if (mode_r == MODE_FAN) begin
      a = held0;
      b = held1;
      held1 = cur;
    end else begin
      a = held0;
      b = held1;
      seen = 0;
    end
    dummy = plane_setup(a, b, cur);
  endfunction

  // word layout, lowest bits first
  function automatic logic [IN_DATA_W-1:0] pack_vert(vert_t v);
    return {v.t, v.s, v.a, v.b, v.g, v.r, v.w, v.z, v.y, v.x};
  endfunction

  // sender: gap draw, then hold valid until accepted
  task automatic push_vert(vert_t v, logic restart);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pack_vert(v);
    s_axis_tuser <= restart;
    do @(posedge clk); while (!s_axis_tready);
    assemble(v, restart);
  endtask

  // registers only change with nothing in flight
  task automatic drain;
    while (s_axis_tvalid || setup_q.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic load_phase(int ph);
    for (int k = 0; k < 6; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= reg_order[k];
      cfg_data <= phase_tab[ph][k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    mode_r = phase_tab[ph][0][1:0];
    cull_r = phase_tab[ph][1][1:0];
    vx_r = phase_tab[ph][2];
    vy_r = phase_tab[ph][3];
    tex_r = phase_tab[ph][4][0];
    en_r = phase_tab[ph][5][0];
  endtask

  function automatic vert_t rand_vert();
    vert_t v;
    if ($urandom_range(0, 3) == 0) begin
      v.x = $urandom;
      v.y = $urandom;
    end else begin
      v.x = $urandom_range(0, 1600) - 800;
      v.y = $urandom_range(0, 1600) - 800;
    end
    // occasional repeated position gives zero area
    if ($urandom_range(0, 9) == 0) begin
      v.x = prev_v.x;
      v.y = prev_v.y;
    end
    v.z = $urandom;
    v.w = $urandom;
    v.r = $urandom;
    v.g = $urandom;
    v.b = $urandom;
    v.a = $urandom;
    v.s = $urandom;
    v.t = $urandom;
    return v;
  endfunction

  // receiver: stall draw per word, then check against the oldest setup word
  initial begin
    int stall;
    setup_word_t want;
    logic [15:0] gpos;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      if (setup_q.size() == 0) begin
        report("unexpected word, param", m_axis_tuser, 0);
      end else begin
        want = setup_q.pop_front();
        if (m_axis_tuser !== want.pid) report("param_id", m_axis_tuser, want.pid);
        if (m_axis_tdata[63:0] !== want.start) report("start", m_axis_tdata[63:0], want.start);
        if (m_axis_tdata[127:64] !== want.sx) report("step_x", m_axis_tdata[127:64], want.sx);
        if (m_axis_tdata[191:128] !== want.sy) report("step_y", m_axis_tdata[191:128], want.sy);
        for (int i = 0; i < 6; i++) begin
          gpos = m_axis_tdata[192 + 16*i +: 16];
          if (gpos !== want.pos[i]) report("vertex position", gpos, want.pos[i]);
        end
        if (m_axis_tlast !== want.last) report("last", m_axis_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    vert_t v;
    int before_cnt;
    mode_r = '0; cull_r = '0; vx_r = '0; vy_r = '0; tex_r = 1'b0; en_r = 1'b1;
    seen = 0; parity = 1'b0;
    prev_v = '{default: '0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under reset config
    for (int i = 0; i < N_ROWS; i++) begin
      v.x = dir_tab[i].x; v.y = dir_tab[i].y;
      v.z = dir_tab[i].z; v.w = dir_tab[i].w;
      v.r = dir_tab[i].r; v.g = dir_tab[i].g;
      v.b = dir_tab[i].b; v.a = dir_tab[i].a;
      v.s = dir_tab[i].s; v.t = dir_tab[i].t;
      before_cnt = setup_q.size();
      push_vert(v, dir_tab[i].restart);
      if (dir_tab[i].tri_known) begin
        // zero area: red start typed, both steps must be zero
        if (setup_q.size() <= before_cnt) begin
          report("typed triangle missing", setup_q.size(), before_cnt + 6);
        end else begin
          if (setup_q[before_cnt].start != dir_tab[i].red_start)
            report("typed red start", setup_q[before_cnt].start, dir_tab[i].red_start);
          if (setup_q[before_cnt].sx != 0 || setup_q[before_cnt].sy != 0)
            report("typed zero step", setup_q[before_cnt].sx, 0);
        end
      end
    end
    drain();

    // random phases; assembly state carries over between them
    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_phase(ph);
      calm = (ph % 3 == 1);
      for (int k = 0; k < RAND_ITEMS; k++) begin
        v = rand_vert();
        push_vert(v, $urandom_range(0, 9) == 0);
        prev_v = v;
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errs == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/tsg_pkg.sv
rtl/tsg_div.sv
rtl/triangle_setup_gradients_unit.sv
rtl/tsg_checker.sv
test/tb_triangle_setup_gradients_unit.sv
